[hdl/dsn_pkg.sv]
`default_nettype none
package dsn_pkg;

   // Field widths of the request and response words.
   localparam int RATE_IN_W = 32;
   localparam int INDEX_W = 16;
   localparam int LENGTH_W = 17;
   localparam int OUT_BITS = 16;

   // Default phase accumulator width.
   localparam int PHASE_BITS_DEF = 32;

   // Interpolation widths: |rate_end - rate_start| * index fits 48 bits.
   localparam int QUO_W = 48;
   localparam int RATE_W = 50;
   localparam int CNT_W = 6;

   // Quarter-wave sine polynomial, Q30 coefficients.
   localparam logic [30:0] Q30_ONE = 31'd1073741824;
   localparam logic [30:0] K1 = 31'd1686629713;
   localparam logic [30:0] K3 = 31'd693598668;
   localparam logic [30:0] K5 = 31'd85569305;
   localparam logic [30:0] K7 = 31'd5026993;
   localparam logic [30:0] K9 = 31'd172272;

   // Output rounding.
   localparam int OUT_SH = 31 - OUT_BITS;
   localparam logic [31:0] OUT_HALF = 32'd1 << (OUT_SH - 1);
   localparam logic [31:0] OUT_MAX = (32'd1 << (OUT_BITS - 1)) - 32'd1;

   // Horner coefficient for steps one to four.
   function automatic logic [30:0] horner_coef(input logic [2:0] step);
      logic [30:0] k;
      case (step)
         3'd1: k = K7;
         3'd2: k = K5;
         3'd3: k = K3;
         3'd4: k = K1;
         default: k = K9;
      endcase
      return k;
   endfunction

   // Round a Q30 magnitude to the output format, clamp it and apply the sign.
   function automatic logic [OUT_BITS-1:0] to_out(input logic [30:0] q30, input logic neg);
      logic [31:0] v;
      v = ({1'b0, q30} + OUT_HALF) >> OUT_SH;
      if (v > OUT_MAX) begin
         v = OUT_MAX;
      end
      if (neg) begin
         v = 32'd0 - v;
      end
      return v[OUT_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

[hdl/dsn_req_if.sv]
`default_nettype none
interface dsn_req_if;
   logic valid;
   logic ready;
   logic signed [dsn_pkg::RATE_IN_W-1:0] rate_start;
   logic signed [dsn_pkg::RATE_IN_W-1:0] rate_end;
   logic [dsn_pkg::INDEX_W-1:0] sample_index;
   logic [dsn_pkg::LENGTH_W-1:0] segment_length;

   modport source(output valid, output rate_start, output rate_end,
                  output sample_index, output segment_length, input ready);
   modport sink(input valid, input rate_start, input rate_end,
                input sample_index, input segment_length, output ready);
endinterface
`default_nettype wire

[hdl/dsn_rsp_if.sv]
`default_nettype none
interface dsn_rsp_if;
   logic valid;
   logic ready;
   logic signed [dsn_pkg::OUT_BITS-1:0] cos_out;
   logic signed [dsn_pkg::OUT_BITS-1:0] sin_out;

   modport source(output valid, output cos_out, output sin_out, input ready);
   modport sink(input valid, input cos_out, input sin_out, output ready);
endinterface
`default_nettype wire

[hdl/dsn_front.sv]
`default_nettype none
module dsn_front (
   input  wire logic clock,
   input  wire logic reset,
   dsn_req_if.sink   req_chan,
   output logic      push_valid,
   input  wire logic push_ready,
   output logic [dsn_pkg::RATE_W-1:0] push_data
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL  = 4'b0010,
      F_DIV  = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic signed [dsn_pkg::RATE_IN_W-1:0] rs_ff, rs_in, re_ff, re_in;
   logic [dsn_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic [dsn_pkg::LENGTH_W-1:0] len_ff, len_in;
   logic dneg_ff, dneg_in;
   logic [dsn_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [dsn_pkg::LENGTH_W-1:0] rem_ff, rem_in;
   logic [dsn_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic signed [dsn_pkg::RATE_IN_W:0] diff;
   logic [dsn_pkg::RATE_IN_W:0] dabs;
   logic [dsn_pkg::LENGTH_W:0] trial;
   logic [dsn_pkg::RATE_W-1:0] quo_signed;

   assign req_chan.ready = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);

   // Signed difference of the segment end points and its magnitude.
   assign diff = {re_ff[dsn_pkg::RATE_IN_W-1], re_ff} - {rs_ff[dsn_pkg::RATE_IN_W-1], rs_ff};
   assign dabs = diff[dsn_pkg::RATE_IN_W] ? (~diff + 1'b1) : diff;

   // One restoring divide step.
   assign trial = {rem_ff, quo_ff[dsn_pkg::QUO_W-1]};

   // The interpolated rate: start plus the signed quotient.
   assign quo_signed = dneg_ff ? (dsn_pkg::RATE_W'(0) - dsn_pkg::RATE_W'(quo_ff))
                               : dsn_pkg::RATE_W'(quo_ff);
   assign push_data = dsn_pkg::RATE_W'(rs_ff) + quo_signed;

   // Sequencer: latch, multiply, divide bit by bit (skipped for a zero length), hand the rate on.
   always_comb begin
      state_in = state_ff;
      rs_in = rs_ff;
      re_in = re_ff;
      idx_in = idx_ff;
      len_in = len_ff;
      dneg_in = dneg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_chan.valid) begin
               rs_in = req_chan.rate_start;
               re_in = req_chan.rate_end;
               idx_in = req_chan.sample_index;
               len_in = req_chan.segment_length;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            dneg_in = diff[dsn_pkg::RATE_IN_W];
            rem_in = '0;
            cnt_in = '0;
            if (len_ff == '0) begin
               quo_in = '0;
               state_in = F_PUSH;
            end else begin
               quo_in = dabs[dsn_pkg::RATE_IN_W-1:0] * idx_ff;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            if (trial >= {1'b0, len_ff}) begin
               rem_in = dsn_pkg::LENGTH_W'(trial - {1'b0, len_ff});
               quo_in = {quo_ff[dsn_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in = trial[dsn_pkg::LENGTH_W-1:0];
               quo_in = {quo_ff[dsn_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == dsn_pkg::CNT_W'(dsn_pkg::QUO_W - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rs_ff <= rs_in;
      re_ff <= re_in;
      idx_ff <= idx_in;
      len_ff <= len_in;
      dneg_ff <= dneg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

endmodule
`default_nettype wire

[hdl/dsn_queue.sv]
`default_nettype none
module dsn_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   output logic      push_ready,
   input  wire logic [dsn_pkg::RATE_W-1:0] push_data,
   output logic      pop_valid,
   input  wire logic pop_ready,
   output logic [dsn_pkg::RATE_W-1:0] pop_data
);

   logic [dsn_pkg::RATE_W-1:0] entry_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   // Two-entry queue of rates between the front and back.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[hdl/dsn_back.sv]
`default_nettype none
module dsn_back #(
   parameter int PHASE_BITS = dsn_pkg::PHASE_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [31:0] gain,
   input  wire logic pop_valid,
   output logic      pop_ready,
   input  wire logic [dsn_pkg::RATE_W-1:0] pop_data,
   dsn_rsp_if.source rsp_chan
);

   localparam int RW = dsn_pkg::RATE_W;
   localparam logic [RW-1:0] LIM_NEG = RW'(1) << (PHASE_BITS - 1);
   localparam logic [RW-1:0] LIM_POS = LIM_NEG - RW'(1);

   typedef enum logic [5:0] {
      B_IDLE = 6'b000001,
      B_HI   = 6'b000010,
      B_LO   = 6'b000100,
      B_ACC  = 6'b001000,
      B_POLY = 6'b010000,
      B_DONE = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic neg_ff, neg_in;
   logic [RW-1:0] mag_ff, mag_in, hi_ff, hi_in, q_ff, q_in;
   logic [1:0] quad_ff, quad_in;
   logic sel_ff, sel_in;
   logic [2:0] step_ff, step_in;
   logic [30:0] x_ff, x_in, x2_ff, x2_in, acc_ff, acc_in, s_ff, s_in, c_ff, c_in;
   logic out_valid_ff, out_valid_in;
   logic [dsn_pkg::OUT_BITS-1:0] cos_ff, cos_in, sin_ff, sin_in;

   logic [31:0] ma, mb;
   logic [63:0] prod;
   logic [30:0] prod_q30;
   logic [RW-1:0] qsat, incw;
   logic [PHASE_BITS-1:0] phase_next;
   logic [31:0] u_next;
   logic out_free;

   assign pop_ready = (state_ff == B_IDLE);
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.cos_out = cos_ff;
   assign rsp_chan.sin_out = sin_ff;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   // The one shared multiplier.
   assign prod = ma * mb;
   assign prod_q30 = prod[60:30];

   always_comb begin
      ma = '0;
      mb = '0;
      case (state_ff)
         B_HI: begin
            ma = 32'(mag_ff[RW-1:32]);
            mb = gain;
         end
         B_LO: begin
            ma = mag_ff[31:0];
            mb = gain;
         end
         B_POLY: begin
            if (step_ff == 3'd0) begin
               ma = {1'b0, x_ff};
               mb = {1'b0, x_ff};
            end else if (step_ff == 3'd5) begin
               ma = {1'b0, x_ff};
               mb = {1'b0, acc_ff};
            end else begin
               ma = {1'b0, x2_ff};
               mb = {1'b0, acc_ff};
            end
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   // Saturated increment and the updated phase.
   assign qsat = neg_ff ? ((q_ff > LIM_NEG) ? LIM_NEG : q_ff)
                        : ((q_ff > LIM_POS) ? LIM_POS : q_ff);
   assign incw = neg_ff ? (RW'(0) - qsat) : qsat;
   assign phase_next = phase_ff + incw[PHASE_BITS-1:0];

   // Align the phase to 32 bits.
   generate
      if (PHASE_BITS >= 32) begin : g_wide
         assign u_next = phase_next[PHASE_BITS-1 -: 32];
      end else begin : g_narrow
         assign u_next = {phase_next, {(32 - PHASE_BITS){1'b0}}};
      end
   endgenerate

   // Sequencer: gain product, accumulate, two quarter-wave polynomials, output.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      hi_in = hi_ff;
      q_in = q_ff;
      quad_in = quad_ff;
      sel_in = sel_ff;
      step_in = step_ff;
      x_in = x_ff;
      x2_in = x2_ff;
      acc_in = acc_ff;
      s_in = s_ff;
      c_in = c_ff;
      cos_in = cos_ff;
      sin_in = sin_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               neg_in = pop_data[RW-1];
               mag_in = pop_data[RW-1] ? (RW'(0) - pop_data) : pop_data;
               state_in = B_HI;
            end
         end
         B_HI: begin
            hi_in = prod[RW-1:0];
            state_in = B_LO;
         end
         B_LO: begin
            if (hi_ff[RW-1:32] != '0) begin
               q_in = LIM_NEG;
            end else begin
               q_in = (hi_ff << 16) + RW'(prod[63:16]);
            end
            state_in = B_ACC;
         end
         B_ACC: begin
            phase_in = phase_next;
            quad_in = u_next[31:30];
            x_in = {1'b0, u_next[29:0]};
            acc_in = dsn_pkg::K9;
            sel_in = 1'b0;
            step_in = 3'd0;
            state_in = B_POLY;
         end
         B_POLY: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd0) begin
               x2_in = prod_q30;
            end else if (step_ff == 3'd5) begin
               step_in = 3'd0;
               acc_in = dsn_pkg::K9;
               if (!sel_ff) begin
                  s_in = prod_q30;
                  sel_in = 1'b1;
                  x_in = dsn_pkg::Q30_ONE - x_ff;
               end else begin
                  c_in = prod_q30;
                  state_in = B_DONE;
               end
            end else begin
               acc_in = dsn_pkg::horner_coef(step_ff) - prod_q30;
            end
         end
         B_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               case (quad_ff)
                  2'd0: begin
                     cos_in = dsn_pkg::to_out(c_ff, 1'b0);
                     sin_in = dsn_pkg::to_out(s_ff, 1'b0);
                  end
                  2'd1: begin
                     cos_in = dsn_pkg::to_out(s_ff, 1'b1);
                     sin_in = dsn_pkg::to_out(c_ff, 1'b0);
                  end
                  2'd2: begin
                     cos_in = dsn_pkg::to_out(c_ff, 1'b1);
                     sin_in = dsn_pkg::to_out(s_ff, 1'b1);
                  end
                  default: begin
                     cos_in = dsn_pkg::to_out(s_ff, 1'b0);
                     sin_in = dsn_pkg::to_out(c_ff, 1'b1);
                  end
               endcase
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Control state and the phase accumulator.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         phase_ff <= '0;
         out_valid_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         out_valid_ff <= out_valid_in;
         step_ff <= step_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      hi_ff <= hi_in;
      q_ff <= q_in;
      quad_ff <= quad_in;
      sel_ff <= sel_in;
      x_ff <= x_in;
      x2_ff <= x2_in;
      acc_ff <= acc_in;
      s_ff <= s_in;
      c_ff <= c_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   // The phase moves only in the accumulate step.
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != B_ACC) |=> $stable(phase_ff))
      else $error("phase changed outside the accumulate step");

   // A new response word is loaded only from the output step.
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid_in && !(out_valid_ff && !rsp_chan.ready)) |-> (state_ff == B_DONE))
      else $error("response loaded outside the output step");

   // The polynomial step count stays within one Horner pass.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 3'd5)
      else $error("polynomial step out of range");

endmodule
`default_nettype wire

[hdl/doppler_sweep_nco.sv]
// Doppler sweep oscillator.
// req_chan carries one word per output sample: the segment's start and end
// range rates, the sample index and the segment length. rsp_chan returns one
// word per request with the cosine and sine of the updated phase.
// csr_write_en / csr_write_data load the Doppler gain; write it only while
// the block is idle.
// The front interpolates the rate with a multiply and a restoring divider
// that resolves one quotient bit per cycle; it takes no new word until the
// last has passed the multiply, the 48 divide steps and the hand-off.
// The back applies the gain, accumulates the phase and evaluates both
// quarter-wave polynomials on one shared multiplier.
// A two-entry rate queue sits between them, so the back works while the
// front takes the next word.
// Reset clears the phase accumulator, the gain and all handshake state.
// When the receiver stalls, the output register holds its word, the back
// then the queue fill up, and req_chan.ready drops.
`default_nettype none
module doppler_sweep_nco #(
   parameter int PHASE_BITS = dsn_pkg::PHASE_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   dsn_req_if.sink   req_chan,
   dsn_rsp_if.source rsp_chan,
   input  wire logic csr_write_en,
   input  wire logic [31:0] csr_write_data
);

   logic [31:0] gain_ff;
   logic push_valid, push_ready, pop_valid, pop_ready;
   logic [dsn_pkg::RATE_W-1:0] push_data, pop_data;

   // Gain register.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
      end else if (csr_write_en) begin
         gain_ff <= csr_write_data;
      end
   end

   dsn_front u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_data)
   );

   dsn_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_data),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data(pop_data)
   );

   dsn_back #(.PHASE_BITS(PHASE_BITS)) u_back (
      .clock(clock),
      .reset(reset),
      .gain(gain_ff),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data(pop_data),
      .rsp_chan(rsp_chan)
   );

endmodule
`default_nettype wire
